>>> hw/rtl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Types, codes and helper functions shared by the shadow register field codec.
// ----------------------------------------------------------------------------
package sfc_pkg;

	localparam int SFC_MAX_WORDS = 4;

	localparam logic SFC_REQ_READ  = 1'b0;
	localparam logic SFC_REQ_WRITE = 1'b1;

	localparam logic SFC_KIND_VALUE = 1'b0;
	localparam logic SFC_KIND_PAIR  = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [15:0] reg_addr;
		logic [15:0] raw_pair;
		logic        last_word;
		logic [2:0]  width_words;
		logic        byte_le;
		logic        word_le;
		logic [5:0]  bit_offset;
		logic [6:0]  bit_width;
		logic [63:0] field_value;
		logic        use_cache;
	} sfc_req_t;

	typedef struct packed {
		logic        out_kind;
		logic [63:0] out_value;
		logic [15:0] out_pair;
		logic        out_last;
	} sfc_rsp_t;

	// Request after decode: byte order applied to read words, width clamped
	typedef struct packed {
		logic        is_write;
		logic [15:0] addr;
		logic [15:0] word;
		logic        last;
		logic [2:0]  words;
		logic        byte_le;
		logic        word_le;
		logic [5:0]  off;
		logic [6:0]  bw;
		logic [63:0] value;
		logic        use_cache;
	} sfc_item_t;

	function automatic logic [15:0] order_bytes(input logic [15:0] w, input logic le);
		return le ? {w[7:0], w[15:8]} : w;
	endfunction

	function automatic logic [63:0] lsb_mask(input logic [6:0] bits);
		logic [63:0] m;
		m = (64'd1 << bits[5:0]) - 64'd1;
		return bits[6] ? '1 : m;
	endfunction

endpackage

>>> hw/rtl/sfc_front.sv
// ----------------------------------------------------------------------------
// sfc_front
// Accepts requests, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sfc_front import sfc_pkg::*; #(
	parameter int MAX_WIDTH_WORDS = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  sfc_req_t  req,
	input  logic      busy,
	output logic      item_valid,
	output sfc_item_t item,
	input  logic      item_take
);

	localparam logic [2:0] MAXW = 3'(MAX_WIDTH_WORDS);

	sfc_item_t  ent_q [2];
	sfc_item_t  dec;
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	always_comb begin
		dec.is_write  = (req.req_type == SFC_REQ_WRITE);
		dec.addr      = req.reg_addr;
		dec.word      = order_bytes(req.raw_pair, req.byte_le);
		dec.last      = req.last_word;
		if (req.width_words == 3'd0) begin
			dec.words = 3'd1;
		end else if (req.width_words > MAXW) begin
			dec.words = MAXW;
		end else begin
			dec.words = req.width_words;
		end
		dec.byte_le   = req.byte_le;
		dec.word_le   = req.word_le;
		dec.off       = req.bit_offset;
		dec.bw        = req.bit_width;
		dec.value     = req.field_value;
		dec.use_cache = req.use_cache;
	end

	assign req_stall  = busy || (cnt_q == 2'd2);
	assign push       = req_valid && !req_stall;
	assign item_valid = (cnt_q != 2'd0);
	assign item       = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (item_take) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(item_take);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= dec;
		end
	end

endmodule

>>> hw/rtl/sfc_back.sv
// ----------------------------------------------------------------------------
// sfc_back
// Executes queued requests against the shadow cache and drives the results.
// ----------------------------------------------------------------------------
module sfc_back import sfc_pkg::*; #(
	parameter int CACHE_WORDS     = 65536,
	parameter int MAX_WIDTH_WORDS = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  sfc_item_t item,
	output logic      item_take,
	output logic      busy,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output sfc_rsp_t  rsp
);

	localparam int AW = $clog2(CACHE_WORDS);
	localparam logic [32:0] RECIP = 33'((64'd1 << 32) / CACHE_WORDS);
	localparam logic [2:0] MAXW = 3'(MAX_WIDTH_WORDS);

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_MOD1 = 4'd2;
	localparam logic [3:0] ST_MOD2 = 4'd3;
	localparam logic [3:0] ST_RACC = 4'd4;
	localparam logic [3:0] ST_RFIN = 4'd5;
	localparam logic [3:0] ST_ROUT = 4'd6;
	localparam logic [3:0] ST_WRD  = 4'd7;
	localparam logic [3:0] ST_WWT  = 4'd8;
	localparam logic [3:0] ST_WMRG = 4'd9;
	localparam logic [3:0] ST_WOUT = 4'd10;

	logic [3:0]    state_q;
	logic [AW-1:0] clr_idx_q;
	logic [63:0]   acc_q;
	logic [2:0]    cnt_q;
	logic [AW-1:0] rs_q;
	logic [15:0]   ra_q;
	logic [1:0]    k_q;
	logic          rd_pend_s1;
	logic [1:0]    rd_idx_s1;
	logic          rsp_valid_q;

	sfc_item_t     cur_q;
	logic [48:0]   prod_q;
	logic [AW-1:0] slot_q;
	logic [63:0]   val_q;
	logic [63:0]   wacc_q;
	logic [15:0]   words_q [SFC_MAX_WORDS];
	logic [15:0]   rdata_q;
	sfc_rsp_t      rsp_q;
	logic [15:0]   cache_q [CACHE_WORDS];

	logic          can_emit;
	logic          emit;
	sfc_rsp_t      emit_rsp;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [15:0]   mem_wd;
	logic [32:0]   rem_raw, rem_fix;
	logic [AW-1:0] rs_next;
	logic [63:0]   base_acc, new_acc, rd_v, wr_v;
	logic [2:0]    base_cnt;
	logic          k_last;
	logic [1:0]    wpos;
	logic [15:0]   wout;

	assign can_emit  = !rsp_valid_q || !rsp_stall;
	assign item_take = (state_q == ST_IDLE) && item_valid;
	assign busy      = (state_q == ST_CLR);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// slot = addr mod CACHE_WORDS, quotient from a reciprocal, one correction
	assign rem_raw = {17'd0, cur_q.addr} - 33'(prod_q[47:32]) * 33'(CACHE_WORDS);
	assign rem_fix = (rem_raw >= 33'(CACHE_WORDS)) ? rem_raw - 33'(CACHE_WORDS) : rem_raw;

	assign rs_next = (ra_q == 16'hFFFF || rs_q == AW'(CACHE_WORDS - 1)) ? '0 : rs_q + 1'b1;

	assign base_cnt = (cnt_q >= MAXW) ? 3'd0 : cnt_q;
	assign base_acc = (cnt_q >= MAXW) ? 64'd0 : acc_q;
	assign new_acc  = {base_acc[47:0], cur_q.word};

	assign k_last = ({1'b0, k_q} == cur_q.words - 3'd1);
	assign wpos   = cur_q.word_le ? k_q : 2'(cur_q.words - 3'd1 - {1'b0, k_q});
	assign wout   = 16'(wacc_q >> {wpos, 4'b0000});

	// word order of the finished read
	always_comb begin
		rd_v = '0;
		if (cur_q.word_le) begin
			for (int i = 0; i < SFC_MAX_WORDS; i++) begin
				for (int j = 0; j < SFC_MAX_WORDS; j++) begin
					if (3'(i) < cnt_q && 3'(j) == cnt_q - 3'(i) - 3'd1) begin
						rd_v[16*j +: 16] = acc_q[16*i +: 16];
					end
				end
			end
		end else begin
			rd_v = acc_q;
		end
	end

	// assemble cached words and merge the field
	always_comb begin
		wr_v = '0;
		if (cur_q.use_cache) begin
			for (int k = 0; k < SFC_MAX_WORDS; k++) begin
				for (int p = 0; p < SFC_MAX_WORDS; p++) begin
					if (3'(k) < cur_q.words && ((cur_q.word_le && p == k) ||
						(!cur_q.word_le && 3'(p) == cur_q.words - 3'd1 - 3'(k)))) begin
						wr_v[16*p +: 16] = words_q[k];
					end
				end
			end
			wr_v = wr_v & ~(lsb_mask(cur_q.bw) << cur_q.off);
		end
		wr_v = wr_v | (cur_q.value << cur_q.off);
	end

	always_comb begin
		emit     = 1'b0;
		emit_rsp = '0;
		mem_we   = 1'b0;
		mem_wa   = rs_q;
		mem_wd   = wout;
		case (state_q)
			ST_CLR: begin
				mem_we = 1'b1;
				mem_wa = clr_idx_q;
				mem_wd = '0;
			end
			ST_RACC: begin
				mem_we = cur_q.use_cache;
				mem_wa = slot_q;
				mem_wd = cur_q.word;
			end
			ST_ROUT: begin
				emit               = can_emit;
				emit_rsp.out_kind  = SFC_KIND_VALUE;
				emit_rsp.out_value = val_q & lsb_mask(cur_q.bw);
				emit_rsp.out_last  = 1'b1;
			end
			ST_WOUT: begin
				emit              = can_emit;
				mem_we            = can_emit && cur_q.use_cache;
				emit_rsp.out_kind = SFC_KIND_PAIR;
				emit_rsp.out_pair = order_bytes(wout, cur_q.byte_le);
				emit_rsp.out_last = k_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cache_q[mem_wa] <= mem_wd;
		end
		rdata_q <= cache_q[rs_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_idx_q   <= '0;
			acc_q       <= '0;
			cnt_q       <= '0;
			rs_q        <= '0;
			ra_q        <= '0;
			k_q         <= '0;
			rd_pend_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= 1'b0;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == AW'(CACHE_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_MOD1;
					end
				end
				ST_MOD1: begin
					state_q <= ST_MOD2;
				end
				ST_MOD2: begin
					rs_q <= rem_fix[AW-1:0];
					ra_q <= cur_q.addr;
					k_q  <= '0;
					if (!cur_q.is_write) begin
						state_q <= ST_RACC;
					end else if (cur_q.use_cache) begin
						state_q <= ST_WRD;
					end else begin
						state_q <= ST_WMRG;
					end
				end
				ST_RACC: begin
					acc_q   <= new_acc;
					cnt_q   <= base_cnt + 3'd1;
					state_q <= cur_q.last ? ST_RFIN : ST_IDLE;
				end
				ST_RFIN: begin
					state_q <= ST_ROUT;
				end
				ST_ROUT: begin
					if (can_emit) begin
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_WRD: begin
					rd_pend_s1 <= 1'b1;
					rs_q       <= rs_next;
					ra_q       <= ra_q + 16'd1;
					k_q        <= k_q + 2'd1;
					if (k_last) begin
						state_q <= ST_WWT;
					end
				end
				ST_WWT: begin
					state_q <= ST_WMRG;
				end
				ST_WMRG: begin
					rs_q    <= slot_q;
					ra_q    <= cur_q.addr;
					k_q     <= '0;
					state_q <= ST_WOUT;
				end
				ST_WOUT: begin
					if (can_emit) begin
						rs_q <= rs_next;
						ra_q <= ra_q + 16'd1;
						k_q  <= k_q + 2'd1;
						if (k_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= k_q;
		if (item_take) begin
			cur_q <= item;
		end
		if (state_q == ST_MOD1) begin
			prod_q <= 49'(cur_q.addr) * 49'(RECIP);
		end
		if (state_q == ST_MOD2) begin
			slot_q <= rem_fix[AW-1:0];
		end
		if (state_q == ST_RFIN) begin
			val_q <= rd_v >> cur_q.off;
		end
		if (state_q == ST_WMRG) begin
			wacc_q <= wr_v;
		end
		if (rd_pend_s1) begin
			words_q[rd_idx_s1] <= rdata_q;
		end
		if (emit) begin
			rsp_q <= emit_rsp;
		end
	end

endmodule

>>> hw/rtl/shadow_register_field_codec_unit.sv
// Sequence: each read word passes the states MOD1, MOD2 and RACC; the last word of a
// register then passes RFIN and ROUT to emit the extracted value. A write passes MOD1,
// MOD2, WRD per word, WWT, WMRG and WOUT per word, or skips WRD and WWT without the cache.
// One request is executed at a time by the back-end sequencer and its cache port.
// After reset the cache is cleared one entry per cycle;
// requests are stalled until the clear completes.
// ----------------------------------------------------------------------------
// shadow_register_field_codec_unit
// Shadow register cache with bit field pack and unpack.
// ----------------------------------------------------------------------------
module shadow_register_field_codec_unit import sfc_pkg::*; #(
	parameter int CACHE_WORDS     = 65536,
	parameter int MAX_WIDTH_WORDS = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  sfc_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output sfc_rsp_t rsp
);

	logic      item_valid;
	logic      item_take;
	logic      busy;
	sfc_item_t item;

	sfc_front #(
		.MAX_WIDTH_WORDS(MAX_WIDTH_WORDS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.busy      (busy),
		.item_valid(item_valid),
		.item      (item),
		.item_take (item_take)
	);

	sfc_back #(
		.CACHE_WORDS    (CACHE_WORDS),
		.MAX_WIDTH_WORDS(MAX_WIDTH_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item      (item),
		.item_take (item_take),
		.busy      (busy),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> req_stall) else $error("request accepted during cache clear");

	a_value_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_kind == SFC_KIND_VALUE |-> rsp.out_last && rsp.out_pair == 16'd0)
		else $error("extracted value not a single result");

	a_pair_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_kind == SFC_KIND_PAIR |-> rsp.out_value == 64'd0)
		else $error("byte pair carries a value");
`endif

endmodule
